// File: design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types and constants shared by the binary heap priority queue modules.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int ELEM_W = KEY_W + TAG_W;
  localparam int OCC_W = 7;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic [15:0]        tag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [15:0]        out_tag;
    logic               out_valid;
    logic [1:0]         status;
    logic [6:0]         occupancy;
  } out_item_t;

  // queued operation from front to back
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic [15:0]        tag;
  } op_t;

  // a goes strictly above b under the selected order
  function automatic logic goes_before(input logic [ELEM_W-1:0] a,
                                       input logic [ELEM_W-1:0] b,
                                       input logic max_first);
    logic [ELEM_W-1:0] ra;
    logic [ELEM_W-1:0] rb;
    ra = {~a[ELEM_W-1], a[ELEM_W-2:0]};
    rb = {~b[ELEM_W-1], b[ELEM_W-2:0]};
    return max_first ? (ra > rb) : (ra < rb);
  endfunction

endpackage

// File: design/bhpq_front.sv
// ----------------------------------------------------------------------------
// bhpq_front
// Input stage: accepts items and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module bhpq_front import bhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output op_t      q_op,
  input  logic     q_take
);

  localparam int QD = 2;

  op_t        mem_r [QD];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_op     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{cmd: in_data.cmd, key: in_data.key, tag: in_data.tag};
    end
  end

endmodule

// File: design/bhpq_engine.sv
// ----------------------------------------------------------------------------
// bhpq_engine
// Heap engine: runs sift-up and sift-down over a one-port-write memory.
// ----------------------------------------------------------------------------
module bhpq_engine import bhpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      order_mode,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_UPRD  = 8'b00000010,
    S_UPCMP = 8'b00000100,
    S_DNRDL = 8'b00001000,
    S_DNRDR = 8'b00010000,
    S_DNCMP = 8'b00100000,
    S_WRAP  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ELEM_W-1:0] mem_r [CAPACITY];
  logic [ELEM_W-1:0] rd_r;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ELEM_W-1:0] wdata;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW:0]       pos_r, pos_nxt;
  logic [ELEM_W-1:0] cur_r, cur_nxt;
  logic [ELEM_W-1:0] lv_r, lv_nxt;
  logic              has_r_r, has_r_nxt;
  logic              lok_r, lok_nxt;
  out_item_t         res_r, res_nxt;
  logic              ov_r, ov_nxt;

  logic [CW:0] up_idx, lch, rch;
  logic [ELEM_W-1:0] in_elem;

  assign in_elem = {q_op.key, q_op.tag};
  assign up_idx  = (pos_r - 1'b1) >> 1;
  assign lch     = {pos_r[CW-1:0], 1'b1};
  assign rch     = lch + 1'b1;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rd_r <= mem_r[raddr];
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign q_take    = (state_r == S_IDLE) && q_valid && !ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    lv_nxt    = lv_r;
    has_r_nxt = has_r_r;
    lok_nxt   = lok_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && out_stall;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = cur_r;
    case (state_r)
      S_IDLE: begin
        if (q_take) begin
          res_nxt = '0;
          if (q_op.cmd == CMD_PUSH) begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_nxt.status    = ST_FULL;
              res_nxt.occupancy = OCC_W'(cnt_r);
              state_nxt = S_OUT;
            end else begin
              cur_nxt = in_elem;
              pos_nxt = (CW+1)'(cnt_r);
              cnt_nxt = cnt_r + 1'b1;
              res_nxt.occupancy = OCC_W'(cnt_r + 1'b1);
              state_nxt = S_UPRD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_nxt.status = ST_EMPTY;
              state_nxt = S_OUT;
            end else begin
              // read the root; the last element comes after it
              raddr     = '0;
              cnt_nxt   = cnt_r - 1'b1;
              res_nxt.occupancy = OCC_W'(cnt_r - 1'b1);
              res_nxt.out_valid = 1'b1;
              pos_nxt   = '0;
              state_nxt = S_WRAP;
            end
          end
        end
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end else begin
          raddr = AW'(up_idx);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (goes_before(cur_r, rd_r, order_mode)) begin
          we = 1'b1; waddr = AW'(pos_r); wdata = rd_r;
          pos_nxt = up_idx;
          state_nxt = S_UPRD;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end
      end
      S_WRAP: begin
        // rd_r has the root: report it, then fetch the last element
        if (!lok_r) begin
          res_nxt.out_key = rd_r[ELEM_W-1:TAG_W];
          res_nxt.out_tag = rd_r[TAG_W-1:0];
          raddr   = AW'(cnt_r);
          lok_nxt = 1'b1;
        end else begin
          lok_nxt = 1'b0;
          cur_nxt = rd_r;
          if (cnt_r == '0) state_nxt = S_OUT;
          else state_nxt = S_DNRDL;
        end
      end
      S_DNRDL: begin
        if (lch >= (CW+1)'(cnt_r)) begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end else begin
          raddr = AW'(lch);
          has_r_nxt = (rch < (CW+1)'(cnt_r));
          state_nxt = S_DNRDR;
        end
      end
      S_DNRDR: begin
        lv_nxt = rd_r;
        raddr  = AW'(rch);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (has_r_r && goes_before(rd_r, lv_r, order_mode)) begin
          if (goes_before(rd_r, cur_r, order_mode)) begin
            we = 1'b1; waddr = AW'(pos_r); wdata = rd_r;
            pos_nxt = rch; state_nxt = S_DNRDL;
          end else begin
            we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
          end
        end else if (goes_before(lv_r, cur_r, order_mode)) begin
          we = 1'b1; waddr = AW'(pos_r); wdata = lv_r;
          pos_nxt = lch; state_nxt = S_DNRDL;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      lok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      lok_r   <= lok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    cur_r   <= cur_nxt;
    lv_r    <= lv_nxt;
    has_r_r <= has_r_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap priority queue with push and pop, min-first or max-first.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one command per beat: a push
// of a key and tag, or a pop. Each beat produces exactly one result beat on
// out_valid/out_stall/out_data with the popped element (if any), a status and
// the element count after the command.
// A two-entry queue takes input beats while the heap engine works. The engine
// handles one command at a time over a memory with one write port and
// registered reads: a push reads the parent and compares once per level climbed,
// a pop reads the root and then the last element, and reads both children and
// compares once per level descended; rejected commands go straight to the result.
// The result register holds while out_stall is high; the engine then waits
// before taking the next command, and the queue fills and raises in_stall.
// cfg_we writes order_mode (0 smallest first, 1 largest first); write it only
// while idle. Synchronous reset empties the heap and clears order_mode.
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic order_r;
  logic q_valid, q_take;
  op_t  q_op;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 1'b0;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  bhpq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_op, .q_take
  );

  bhpq_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk, .rst_n, .order_mode(order_r), .q_valid, .q_op, .q_take,
    .out_valid, .out_stall, .out_data
  );

endmodule

// File: design/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bhpq_checker import bhpq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      !out_data.out_valid && out_data.occupancy == '0)
    else $error("empty pop with data");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> !out_data.out_valid)
    else $error("full push with data");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_EMPTY ||
                   out_data.status == ST_FULL))
    else $error("bad status");

endmodule

bind binary_heap_priority_queue bhpq_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);

// File: dv/tb_binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue
// Self-checking bench for the heap queue: pushes and pops with random idling
// on both channels, a heap predictor in a scoreboard, both order settings.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue;
  import bhpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  class heap_scoreboard;
    logic [ELEM_W-1:0] slots[DEPTH];
    int                fill;
    logic              largest_first;
    out_item_t         pending[$];
    int                errors;

    function new();
      fill = 0;
      largest_first = 1'b0;
      errors = 0;
    endfunction

    function bit above(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
      logic [ELEM_W-1:0] ra;
      logic [ELEM_W-1:0] rb;
      ra = a ^ {1'b1, {(ELEM_W-1){1'b0}}};
      rb = b ^ {1'b1, {(ELEM_W-1){1'b0}}};
      return largest_first ? (ra > rb) : (ra < rb);
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      logic [ELEM_W-1:0] t;
      int p;
      int l;
      int best;
      r = '0;
      if (it.cmd == CMD_PUSH) begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[fill] = {it.key, it.tag};
          p = fill;
          fill++;
          while (p > 0 && above(slots[p], slots[(p-1)/2])) begin
            t = slots[p]; slots[p] = slots[(p-1)/2]; slots[(p-1)/2] = t;
            p = (p - 1) / 2;
          end
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_key = slots[0][ELEM_W-1:TAG_W];
        r.out_tag = slots[0][TAG_W-1:0];
        r.out_valid = 1'b1;
        fill--;
        slots[0] = slots[fill];
        p = 0;
        forever begin
          l = 2 * p + 1;
          best = p;
          if (l < fill && above(slots[l], slots[best])) best = l;
          if (l + 1 < fill && above(slots[l+1], slots[best])) best = l + 1;
          if (best == p) break;
          t = slots[p]; slots[p] = slots[best]; slots[best] = t;
          p = best;
        end
      end
      r.occupancy = fill[6:0];
      pending.insert(pending.size(), r);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", got[47:0], 48'h0);
        return;
      end
      e = pending.pop_front();
      if (got.out_key !== e.out_key)
        report("out_key", {16'h0, got.out_key}, {16'h0, e.out_key});
      if (got.out_tag !== e.out_tag)
        report("out_tag", {32'h0, got.out_tag}, {32'h0, e.out_tag});
      if (got.out_valid !== e.out_valid)
        report("out_valid", {47'h0, got.out_valid}, {47'h0, e.out_valid});
      if (got.status !== e.status)
        report("status", {46'h0, got.status}, {46'h0, e.status});
      if (got.occupancy !== e.occupancy)
        report("occupancy", {41'h0, got.occupancy}, {41'h0, e.occupancy});
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  bit        calm = 1'b0;

  heap_scoreboard sb = new();

  binary_heap_priority_queue #(.CAPACITY(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
  end

  // valid stays high between back to back beats
  task automatic send_beat(in_item_t it);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_order(logic mode);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.largest_first = mode;
  endtask

  function automatic in_item_t make_push(logic signed [31:0] k, logic [15:0] t);
    in_item_t it;
    it.cmd = CMD_PUSH;
    it.key = k;
    it.tag = t;
    return it;
  endfunction

  function automatic in_item_t make_pop();
    in_item_t it;
    it.cmd = CMD_POP;
    it.key = $urandom;
    it.tag = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_beat(int level);
    // bias pushes when low, pops when high
    if ($urandom_range(DEPTH) >= level) begin
      case ($urandom_range(3))
        0: return make_push($urandom_range(3) - 2, 16'($urandom_range(3)));
        1: return make_push({$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff},
                            $urandom_range(1) ? 16'hffff : 16'h0);
        default: return make_push($urandom, 16'($urandom));
      endcase
    end
    return make_pop();
  endfunction

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty pop, extremes, equal keys, tag tie-break
    send_beat(make_pop());
    send_beat(make_push(32'sh7fff_ffff, 16'hffff));
    send_beat(make_push(-32'sh8000_0000, 16'h0000));
    send_beat(make_push(0, 16'h0001));
    send_beat(make_push(0, 16'h0000));
    send_beat(make_push(-1, 16'h5555));
    send_beat(make_push(-1, 16'h5555));
    repeat (7) send_beat(make_pop());
    // fill past capacity, then empty fully
    set_order(1'b1);
    for (int i = 0; i < DEPTH + 2; i++) send_beat(make_push($urandom, 16'($urandom)));
    calm = 1'b1;
    for (int i = 0; i < DEPTH + 2; i++) send_beat(make_pop());
    calm = 1'b0;
    // random phases across order settings
    for (phase = 0; phase < 4; phase++) begin
      set_order(phase[0]);
      for (int i = 0; i < 60; i++) begin
        if (phase == 2 && i == 20) calm = 1'b1;
        if (phase == 2 && i == 50) calm = 1'b0;
        send_beat(random_beat(sb.fill));
      end
      // change order with contents kept, then mix more
      drain();
      set_order(!phase[0]);
      for (int i = 0; i < 20; i++) send_beat(random_beat(sb.fill));
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

endmodule
